/* rtl/core/atc_pkg.sv */
// Shared constants, types and datapath step functions for the tilt and temperature converter.
`default_nettype none
package atc_pkg;

	// Field widths
	localparam int IN_W    = 16;
	localparam int ROLL_W  = 17;
	localparam int PITCH_W = 16;
	localparam int TEMP_W  = 16;

	// Angle path
	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 8;
	localparam int INPUT_SCALE   = 16;
	localparam int ANGLE_FRAC    = 24;
	localparam int TABLE_LEN     = 24;
	localparam int NUM_ITER      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int TBL_IW        = $clog2(TABLE_LEN);
	localparam int CW            = IN_W + INPUT_SCALE + 3;  // sqrt(2) * CORDIC gain headroom
	localparam int ZW            = ANGLE_FRAC + 10;         // range of about +-512 degrees
	localparam int RND_SHIFT     = ANGLE_FRAC - FRACTION_BITS;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd90 <<< ANGLE_FRAC);
	localparam logic signed [ZW-1:0] Z_HALF    = ZW'(1) << (RND_SHIFT - 1);

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	// Square root of (ay^2 + az^2) << 2*INPUT_SCALE, one result bit per stage
	localparam int SUM_W     = 2 * IN_W;
	localparam int RT_W      = IN_W + INPUT_SCALE;
	localparam int RM_W      = RT_W + 3;
	localparam int SQ_STEPS  = RT_W;
	localparam int SUM_STEPS = SUM_W / 2;

	// Temperature: floor(((raw + 6120) * 2^(F-2) + 42) / 85), offset to stay non-negative
	localparam int TEMP_OFFSET_RAW = 6120;  // 18 C at 340 counts per degree
	localparam int TEMP_DIV        = 85;    // 680 / 8
	localparam int TEMP_HALF       = 42;    // rounding term after the same reduction
	localparam int TEMP_SCALE      = FRACTION_BITS - 2;
	localparam int TEMP_NEG_MAX    = (1 << (IN_W - 1)) - TEMP_OFFSET_RAW;
	localparam int TEMP_K          = ((TEMP_NEG_MAX << TEMP_SCALE) / TEMP_DIV) + 1;
	localparam int TEMP_BIAS       = TEMP_HALF + TEMP_DIV * TEMP_K;
	localparam int TN_W            = FRACTION_BITS + 15;
	localparam int TEMP_RSHIFT     = TN_W + 7;
	localparam int TM_W            = TEMP_RSHIFT - 6;
	localparam int TP_W            = TN_W + TM_W;
	localparam longint unsigned TEMP_RECIP = (64'd1 << TEMP_RSHIFT) / TEMP_DIV + 1;

	typedef struct packed {
		logic signed [IN_W-1:0] ax;
		logic signed [IN_W-1:0] ay;
		logic signed [IN_W-1:0] az;
		logic [TEMP_W-1:0]      temp;
		logic [SUM_W-1:0]       sum;
	} side_t;

	typedef struct packed {
		logic [RM_W-1:0] rem;
		logic [RT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
		sqrt_t           r;
		logic [RM_W-1:0] rem_n;
		logic [RM_W-1:0] trial;
		rem_n = {s.rem[RM_W-3:0], pair};
		trial = {1'b0, s.root, 2'b01};
		if (rem_n >= trial) begin
			r.rem  = rem_n - trial;
			r.root = {s.root[RT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem_n;
			r.root = {s.root[RT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Left half plane is folded by a quarter turn first; y >= 0 folds to +90.
	function automatic cordic_t cordic_init(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		cordic_t c;
		c.zero = (x == '0) && (y == '0);
		if (!x[CW-1]) begin
			c.x = x;
			c.y = y;
			c.z = '0;
		end else if (!y[CW-1]) begin
			c.x = y;
			c.y = -x;
			c.z = Z_QUARTER;
		end else begin
			c.x = -y;
			c.y = x;
			c.z = -Z_QUARTER;
		end
		return c;
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input logic [TBL_IW-1:0] idx);
		cordic_t              r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] da;
		xs = c.x;
		ys = c.y;
		dx = ys >>> idx;
		dy = xs >>> idx;
		da = ZW'(ATAN_TABLE[idx]);
		r.zero = c.zero;
		if (!ys[CW-1]) begin
			r.x = xs + dx;
			r.y = ys - dy;
			r.z = c.z + da;
		end else begin
			r.x = xs - dx;
			r.y = ys + dy;
			r.z = c.z - da;
		end
		return r;
	endfunction

	function automatic logic signed [ZW-1:0] angle_round(input cordic_t c);
		logic signed [ZW-1:0] zs;
		zs = c.z + Z_HALF;
		if (c.zero) begin
			return '0;
		end
		return zs >>> RND_SHIFT;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/accel_tilt_and_temp_convert.sv */
// Top level: pipelined roll/pitch (CORDIC atan2) and temperature conversion of raw sensor words.
//
// Takes one accelerometer triple and one raw temperature word per transaction and returns
// roll = atan2(accel_y, accel_z), pitch = atan2(-accel_x, sqrt(accel_y^2 + accel_z^2)),
// both in degrees, and temperature = temp_raw/340 + 18 C, all signed with 8 fraction bits,
// rounded to nearest. An angle whose two arguments are both zero reads 0.
// Throughput is one transaction per clock while the output does not stall. From input to
// output there are three front stages (capture, squares and the divide-by-340 multiply, sum),
// 32 stages of the bit-per-stage square root, one quadrant fold, 16 CORDIC stages and one
// rounding stage. The output side has a one-entry skid buffer, so in_ready is a register and
// the input is still taken in the cycle in which the output stalls.
`default_nettype none
module accel_tilt_and_temp_convert (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [atc_pkg::IN_W-1:0]     accel_x,
	input  wire logic signed [atc_pkg::IN_W-1:0]     accel_y,
	input  wire logic signed [atc_pkg::IN_W-1:0]     accel_z,
	input  wire logic signed [atc_pkg::IN_W-1:0]     temp_raw,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [atc_pkg::ROLL_W-1:0]        roll_deg,
	output logic signed [atc_pkg::PITCH_W-1:0]       pitch_deg,
	output logic signed [atc_pkg::TEMP_W-1:0]        temp_celsius
);
	import atc_pkg::*;

	localparam int SQ0     = 3;
	localparam int CR0     = SQ0 + SQ_STEPS;
	localparam int OUT_IDX = CR0 + NUM_ITER + 1;
	localparam int DEPTH   = OUT_IDX + 1;

	logic             en;
	logic [DEPTH-1:0] vld_s;
	logic             skid_q;

	assign en       = !skid_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: capture, temperature numerator
	logic signed [IN_W-1:0] ax_s1, ay_s1, az_s1;
	logic [TN_W-1:0]        tn_s1;
	logic signed [31:0]     tn_full;

	assign tn_full = ((32'(temp_raw) + 32'(TEMP_OFFSET_RAW)) <<< TEMP_SCALE) + 32'(TEMP_BIAS);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= accel_x;
			ay_s1 <= accel_y;
			az_s1 <= accel_z;
			tn_s1 <= tn_full[TN_W-1:0];
		end
	end

	// Stage 2: squares, reciprocal multiply for /85
	logic signed [IN_W-1:0]  ax_s2, ay_s2, az_s2;
	logic [SUM_W-1:0]        sqy_s2, sqz_s2;
	logic [TP_W-1:0]         tp_s2;
	logic signed [SUM_W-1:0] pyy, pzz;

	assign pyy = SUM_W'(ay_s1) * SUM_W'(ay_s1);
	assign pzz = SUM_W'(az_s1) * SUM_W'(az_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			sqy_s2 <= pyy;
			sqz_s2 <= pzz;
			tp_s2  <= TP_W'(tn_s1) * TP_W'(TEMP_RECIP);
		end
	end

	// Stage 3: radicand sum, temperature result
	side_t side_d3;
	side_t side_s3;

	always_comb begin
		side_d3.ax   = ax_s2;
		side_d3.ay   = ay_s2;
		side_d3.az   = az_s2;
		side_d3.sum  = sqy_s2 + sqz_s2;
		side_d3.temp = TEMP_W'(tp_s2 >> TEMP_RSHIFT) - TEMP_W'(TEMP_K);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_d3;
		end
	end

	// Square root stages; the low radicand bits are all zero
	sqrt_t sq_s [SQ_STEPS];
	side_t sd_s [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		sqrt_t      prev;
		side_t      side_in;
		logic [1:0] pair;

		if (j == 0) begin : g_first
			assign prev    = '0;
			assign side_in = side_s3;
		end else begin : g_next
			assign prev    = sq_s[j-1];
			assign side_in = sd_s[j-1];
		end

		if (j < SUM_STEPS) begin : g_pair
			assign pair = side_in.sum[SUM_W-1-2*j -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[j] <= sqrt_step(prev, pair);
				sd_s[j] <= side_in;
			end
		end
	end

	// Quadrant fold and CORDIC vectoring for both angles side by side
	side_t                sd_last;
	logic signed [CW-1:0] roll_x0, roll_y0, pitch_x0, pitch_y0;
	cordic_t              cr_s [NUM_ITER+1];
	cordic_t              cp_s [NUM_ITER+1];
	logic [TEMP_W-1:0]    tmp_s [NUM_ITER+1];

	assign sd_last  = sd_s[SQ_STEPS-1];
	assign roll_x0  = CW'(signed'(sd_last.az)) <<< INPUT_SCALE;
	assign roll_y0  = CW'(signed'(sd_last.ay)) <<< INPUT_SCALE;
	assign pitch_x0 = CW'(sq_s[SQ_STEPS-1].root);
	assign pitch_y0 = -(CW'(signed'(sd_last.ax)) <<< INPUT_SCALE);

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s[0]  <= cordic_init(roll_x0, roll_y0);
			cp_s[0]  <= cordic_init(pitch_x0, pitch_y0);
			tmp_s[0] <= sd_last.temp;
		end
	end

	for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				cr_s[i+1]  <= cordic_step(cr_s[i], TBL_IW'(i));
				cp_s[i+1]  <= cordic_step(cp_s[i], TBL_IW'(i));
				tmp_s[i+1] <= tmp_s[i];
			end
		end
	end

	// Rounding stage
	logic signed [ROLL_W-1:0]  roll_sl;
	logic signed [PITCH_W-1:0] pitch_sl;
	logic signed [TEMP_W-1:0]  temp_sl;
	logic signed [ZW-1:0]      roll_r, pitch_r;

	assign roll_r  = angle_round(cr_s[NUM_ITER]);
	assign pitch_r = angle_round(cp_s[NUM_ITER]);

	always_ff @(posedge clk) begin
		if (en) begin
			roll_sl  <= roll_r[ROLL_W-1:0];
			pitch_sl <= pitch_r[PITCH_W-1:0];
			temp_sl  <= tmp_s[NUM_ITER];
		end
	end

	// Skid buffer: holds the last stage when the output stalls while the pipe moves
	logic signed [ROLL_W-1:0]  roll_q;
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [TEMP_W-1:0]  temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (out_ready) begin
				skid_q <= 1'b0;
			end
		end else if (vld_s[OUT_IDX] && !out_ready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			roll_q  <= roll_sl;
			pitch_q <= pitch_sl;
			temp_q  <= temp_sl;
		end
	end

	assign out_valid    = skid_q || vld_s[OUT_IDX];
	assign roll_deg     = skid_q ? roll_q  : roll_sl;
	assign pitch_deg    = skid_q ? pitch_q : pitch_sl;
	assign temp_celsius = skid_q ? temp_q  : temp_sl;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the tilt and temperature converter: queued stimulus, streaming predictor, scoreboard.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atc_pkg::*;

	typedef struct packed {
		logic signed [IN_W-1:0] ax;
		logic signed [IN_W-1:0] ay;
		logic signed [IN_W-1:0] az;
		logic signed [IN_W-1:0] traw;
	} sample_t;

	typedef struct packed {
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [TEMP_W-1:0]  temp;
	} reading_t;

	localparam int DEG_FRAC  = 24;
	localparam int ACC_SHIFT = 16;
	localparam int SETTLE    = 80;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam longint ATAN_DEG [24] = '{
		754974720, 445687602, 235489089, 119537938,
		60000934, 30029717, 15018523, 7509720,
		3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335,
		14668, 7334, 3667, 1833,
		917, 458, 229, 115
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [IN_W-1:0]    accel_x = '0;
	logic signed [IN_W-1:0]    accel_y = '0;
	logic signed [IN_W-1:0]    accel_z = '0;
	logic signed [IN_W-1:0]    temp_raw = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [ROLL_W-1:0]  roll_deg;
	logic signed [PITCH_W-1:0] pitch_deg;
	logic signed [TEMP_W-1:0]  temp_celsius;

	sample_t  pending_samples[$];
	reading_t predicted_readings[$];
	sample_t  next_sample;
	reading_t got;
	reading_t want;
	int       total_items = 0;
	int       sent_count = 0;
	int       error_count = 0;
	int       send_idle;
	int       recv_idle;

	accel_tilt_and_temp_convert i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.temp_raw     (temp_raw),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.roll_deg     (roll_deg),
		.pitch_deg    (pitch_deg),
		.temp_celsius (temp_celsius)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact integer square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// atan2(y, x) in degrees with FRACTION_BITS fraction bits, CORDIC vectoring
	function automatic longint atan2_deg(input longint x, input longint y);
		longint z;
		longint t;
		longint dx;
		longint dy;
		int     sh;
		z = 0;
		sh = DEG_FRAC - FRACTION_BITS;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(90) <<< DEG_FRAC;
			end else begin
				x = -y;
				y = t;
				z = -(longint'(90) <<< DEG_FRAC);
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_DEG[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_DEG[i];
			end
		end
		return (z + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic reading_t convert_sample(input sample_t s);
		reading_t        r;
		longint          ax;
		longint          ay;
		longint          az;
		longint          n;
		longint          v;
		longint unsigned mag2;
		longint          den;
		ax = s.ax;
		ay = s.ay;
		az = s.az;
		mag2 = longint'(ay * ay + az * az);
		den = longint'(int_sqrt(mag2 << 32));
		r.roll  = ROLL_W'(atan2_deg(az <<< ACC_SHIFT, ay <<< ACC_SHIFT));
		r.pitch = PITCH_W'(atan2_deg(den, (-ax) <<< ACC_SHIFT));
		// temp_raw/340 + 18, rounded half up
		n = (longint'(s.traw) + 6120) * (longint'(1) <<< FRACTION_BITS);
		v = 2 * n + 340;
		if (v >= 0) r.temp = TEMP_W'(v / 680);
		else r.temp = TEMP_W'(-((-v + 679) / 680));
		return r;
	endfunction

	function automatic logic signed [IN_W-1:0] rand_axis();
		int k;
		k = $urandom_range(99);
		if (k < 40) return IN_W'($urandom());
		if (k < 70) return IN_W'(($urandom_range(1) ? 16384 : -16384)
			+ int'($urandom_range(2000)) - 1000);
		if (k < 85) return IN_W'(int'($urandom_range(128)) - 64);
		if (k < 95) return '0;
		return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
	endfunction

	task automatic add_sample(input int ax, input int ay, input int az, input int t);
		sample_t s;
		s.ax = IN_W'(ax);
		s.ay = IN_W'(ay);
		s.az = IN_W'(az);
		s.traw = IN_W'(t);
		pending_samples.push_back(s);
	endtask

	always_comb begin
		if (sent_count < total_items / 3) begin
			send_idle = 38;
			recv_idle = 51;
		end else if (sent_count < 2 * total_items / 3) begin
			send_idle = 51;
			recv_idle = 38;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// Driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) begin
					predicted_readings.push_back(convert_sample({accel_x, accel_y, accel_z,
						temp_raw}));
					sent_count++;
				end
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
					next_sample = pending_samples.pop_front();
					in_valid <= 1'b1;
					accel_x  <= next_sample.ax;
					accel_y  <= next_sample.ay;
					accel_z  <= next_sample.az;
					temp_raw <= next_sample.traw;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// Monitor and scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{roll_deg, pitch_deg, temp_celsius};
			if (predicted_readings.size() == 0) begin
				$display("%0t: unexpected transaction roll=%0d pitch=%0d temp=%0d", $time,
					roll_deg, pitch_deg, temp_celsius);
				error_count++;
			end else begin
				want = predicted_readings.pop_front();
				if (got.roll !== want.roll) begin
					$display("%0t: roll_deg expected %0d got %0d", $time, want.roll, got.roll);
					error_count++;
				end
				if (got.pitch !== want.pitch) begin
					$display("%0t: pitch_deg expected %0d got %0d", $time, want.pitch,
						got.pitch);
					error_count++;
				end
				if (got.temp !== want.temp) begin
					$display("%0t: temp_celsius expected %0d got %0d", $time, want.temp,
						got.temp);
					error_count++;
				end
			end
		end
	end

	initial begin
		// Directed: extremes, quadrant folds, zero vectors, vertical pitch
		add_sample(0, 0, 0, 0);
		add_sample(0, 0, 16384, -6120);
		add_sample(0, 16384, 0, -6121);
		add_sample(0, 0, -16384, 340);       // y zero, x negative: +180
		add_sample(0, -1, -16384, 170);
		add_sample(0, 1, -16384, -170);
		add_sample(0, -16384, 0, -32768);
		add_sample(16384, 0, 0, 32767);      // pitch -90, zero denominator
		add_sample(-16384, 0, 0, -1);
		add_sample(-32768, 0, 0, 1);
		add_sample(32767, 0, 0, -6290);
		add_sample(0, 32767, 32767, -5950);
		add_sample(0, -32768, -32768, 12345);
		add_sample(0, -32768, 32767, -12345);
		add_sample(0, 32767, -32768, 6120);
		add_sample(1, 1, 1, 2);
		add_sample(-1, -1, -1, -2);
		add_sample(-32768, -32768, -32768, -32768);
		add_sample(32767, 32767, 32767, 32767);
		add_sample(-32768, 32767, -32768, 16'h5555);
		add_sample(11585, 11585, 0, -21846);
		for (int i = 0; i < 1850; i++) begin
			add_sample(rand_axis(), rand_axis(), rand_axis(),
				($urandom_range(3) == 0) ? int'($urandom_range(12000)) - 6000
				: int'(IN_W'($urandom())));
		end
		total_items = pending_samples.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || in_valid) @(posedge clk);
		while (predicted_readings.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("%0t: timeout", $time);
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
